// ===== rtl/core/bpc_pkg.sv =====
// shared types and constants for the button press classifier
package bpc_pkg;

  // timestamp and register widths
  localparam int unsigned TimeW = 32;
  localparam int unsigned CfgW  = 16;
  localparam int unsigned IdxW  = 2;

  // register reset values
  localparam logic [CfgW-1:0] DebounceRst  = 16'd50;
  localparam logic [CfgW-1:0] LongPressRst = 16'd500;
  localparam logic [CfgW-1:0] RepeatRst    = 16'd200;

  // register indexes
  localparam logic [IdxW-1:0] RegDebounce  = 2'd0;
  localparam logic [IdxW-1:0] RegLongPress = 2'd1;
  localparam logic [IdxW-1:0] RegRepeat    = 2'd2;

  // result codes
  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_SHORT = 2'd1,
    EV_LONG  = 2'd2
  } press_event_t;

  // configuration seen by the classifier
  typedef struct packed {
    logic [CfgW-1:0] debounce_ms;
    logic [CfgW-1:0] long_press_ms;
    logic [CfgW-1:0] repeat_ms;
  } cfg_t;

  // status from the classifier
  typedef struct packed {
    logic long_fired;
    logic stable_level;
  } status_t;

endpackage

// ===== rtl/core/bpc_cfg_regs.sv =====
// configuration register file for the button press classifier
module bpc_cfg_regs import bpc_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_valid,
  input  logic [IdxW-1:0] cfg_index,
  input  logic [CfgW-1:0] cfg_data,
  output logic            cfg_ready,
  output cfg_t            cfg
);

  // writes are always taken
  assign cfg_ready = 1'b1;

  // register writes, unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ms   <= DebounceRst;
      cfg.long_press_ms <= LongPressRst;
      cfg.repeat_ms     <= RepeatRst;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        RegDebounce:  cfg.debounce_ms   <= cfg_data;
        RegLongPress: cfg.long_press_ms <= cfg_data;
        RegRepeat:    cfg.repeat_ms     <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/core/bpc_classify.sv =====
// debounce state and press classification for one sample
module bpc_classify import bpc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             level,
  input  logic [TimeW-1:0] now,
  input  cfg_t             cfg,
  output press_event_t     ev,
  output status_t          status
);

  logic             stable_level;
  logic [TimeW-1:0] last_change_time;
  logic [TimeW-1:0] press_start_time;
  logic [TimeW-1:0] last_repeat_time;
  logic             long_fired;

  logic             stable_level_next;
  logic [TimeW-1:0] last_change_time_next;
  logic [TimeW-1:0] press_start_time_next;
  logic [TimeW-1:0] last_repeat_time_next;
  logic             long_fired_next;

  logic [TimeW-1:0] since_change;
  logic [TimeW-1:0] held;
  logic [TimeW-1:0] since_repeat;
  logic             change_ok;
  logic             long_due;

  // wrapping time differences
  assign since_change = now - last_change_time;
  assign held         = now - press_start_time;
  assign since_repeat = now - last_repeat_time;

  assign change_ok = (level != stable_level) &&
                     (since_change > {{(TimeW-CfgW){1'b0}}, cfg.debounce_ms});
  // an accepted press restarts the hold time at zero, so only a held low counts
  assign long_due  = !level && !change_ok &&
                     (held > {{(TimeW-CfgW){1'b0}}, cfg.long_press_ms});

  // next state and event
  always_comb begin
    stable_level_next     = stable_level;
    last_change_time_next = last_change_time;
    press_start_time_next = press_start_time;
    last_repeat_time_next = last_repeat_time;
    long_fired_next       = long_fired;
    ev                    = EV_NONE;
    if (change_ok) begin
      stable_level_next     = level;
      last_change_time_next = now;
      long_fired_next       = 1'b0;
      if (!level) begin
        press_start_time_next = now;
      end else if (!long_fired &&
                   (held < {{(TimeW-CfgW){1'b0}}, cfg.long_press_ms})) begin
        ev = EV_SHORT;
      end
    end
    if (long_due) begin
      if (!long_fired) begin
        long_fired_next       = 1'b1;
        last_repeat_time_next = now;
        ev                    = EV_LONG;
      end else if (since_repeat > {{(TimeW-CfgW){1'b0}}, cfg.repeat_ms}) begin
        last_repeat_time_next = now;
        ev                    = EV_LONG;
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      stable_level     <= 1'b1;
      last_change_time <= '0;
      press_start_time <= '0;
      last_repeat_time <= '0;
      long_fired       <= 1'b0;
    end else if (en) begin
      stable_level     <= stable_level_next;
      last_change_time <= last_change_time_next;
      press_start_time <= press_start_time_next;
      last_repeat_time <= last_repeat_time_next;
      long_fired       <= long_fired_next;
    end
  end

  assign status.long_fired   = long_fired;
  assign status.stable_level = stable_level;

endmodule

// ===== rtl/core/button_press_classifier.sv =====
// top level of the debounced button press classifier
//
//  channel | direction | handshake           | word
//  in      | to block  | in_valid, in_stall  | button_level, now_ms
//  out     | from block| out_valid, out_stall| press_event
//  cfg     | to block  | cfg_valid, cfg_ready| cfg_index, cfg_data
//
// one sample per clock unless a stalled output fills both stages; an accepted sample passes
// through the input register, then classifier logic into the result register
// rst is synchronous: registers return to 50/500/200 ms, state to released
// a stalled output holds the pipeline; the input stalls only when both stages are full
// configuration writes are taken every cycle
module button_press_classifier import bpc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             button_level,
  input  logic [TimeW-1:0] now_ms,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [1:0]       press_event,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [IdxW-1:0]  cfg_index,
  input  logic [CfgW-1:0]  cfg_data
);

  cfg_t             cfg;
  status_t          status;
  press_event_t     ev;
  logic             s1_valid;
  logic             s1_level;
  logic [TimeW-1:0] s1_now;
  logic             advance;

  bpc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_ready (cfg_ready),
    .cfg       (cfg)
  );

  // pipeline moves when the result register is free
  assign advance  = !out_valid || !out_stall;
  assign in_stall = s1_valid && !advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_level <= button_level;
      s1_now   <= now_ms;
    end
  end

  bpc_classify u_classify (
    .clk    (clk),
    .rst    (rst),
    .en     (s1_valid && advance),
    .level  (s1_level),
    .now    (s1_now),
    .cfg    (cfg),
    .ev     (ev),
    .status (status)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      press_event <= ev;
    end
  end

  // input stalls only with both stages full and the output held
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && out_valid && out_stall))
    else $error("input stalled with room in the pipeline");

  // a sample that leaves the input register lands in the result register
  a_sample_moves: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && advance) |=> out_valid)
    else $error("sample lost between stages");

  // the long flag only rises together with a long press word
  a_long_event: assert property (@(posedge clk) disable iff (rst)
    $rose(status.long_fired) |-> (out_valid && press_event == EV_LONG))
    else $error("long flag set without a long press word");

endmodule
